### hdl/ubds_pkg.sv
// ---------------------------------------------------------------------------
// ubds_pkg
// Shared types and constants for the uart baud divisor selector.
// ---------------------------------------------------------------------------
package ubds_pkg;

    localparam int unsigned BAUD_W  = 24;
    localparam int unsigned CLK_W   = 28;
    localparam int unsigned ERR_W   = 20;
    localparam int unsigned DIV_W   = 17;   // holds divisors up to 65536
    localparam int unsigned DIFF_W  = 26;   // |actual - baud| for the x4 mode
    localparam int unsigned PROD_W  = DIFF_W + ERR_W;
    localparam int unsigned OUT_W   = 40;

    localparam logic [ERR_W-1:0] PPM_SCALE = ERR_W'(1000000);
    localparam logic [ERR_W-1:0] ERR_MAX   = '1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic {
        CFG_CLOCK_HZ  = 1'b0,
        CFG_MAX_ERROR = 1'b1
    } t_cfg_index;

endpackage

### hdl/uart_baud_divisor_select.sv
// ---------------------------------------------------------------------------
// uart_baud_divisor_select
// Picks the x16 or x4 divisor with the lower baud error for a requested rate.
// ---------------------------------------------------------------------------
// channel   direction  payload
// s_axis    in         tdata[23:0] req_rate
// m_axis    out        tdata[1:0] status, [17:2] divisor_minus_one,
//                      [18] fast_mode, [38:19] err_ppm
// cfg       in         i_cfg_index 0 clock_hz, 1 max_err; i_cfg_data
//
// one request per cycle while m_axis is not stalled; the pipeline is three
// rows of one-bit division cells (28 for clock/baud, 28 for clock/divisor,
// 46 for the ppm error) plus four register stages.
// a stall at m_axis freezes the whole pipeline; s_axis_tready follows it.
// reset is synchronous; it clears the valid bits and loads the register
// defaults. cfg writes are taken every cycle.
// ---------------------------------------------------------------------------
module uart_baud_divisor_select #(
    parameter int unsigned DIVISOR_LIMIT = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // req_rate
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // status, divisor_minus_one, fast_mode, err_ppm
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [27:0] i_cfg_data
);

    localparam int unsigned BW = ubds_pkg::BAUD_W;
    localparam int unsigned CW = ubds_pkg::CLK_W;
    localparam int unsigned EW = ubds_pkg::ERR_W;
    localparam int unsigned DV = ubds_pkg::DIV_W;
    localparam int unsigned FW = ubds_pkg::DIFF_W;
    localparam int unsigned PW = ubds_pkg::PROD_W;

    logic          w_en;
    logic [CW-1:0] r_clock_hz;
    logic [EW-1:0] r_max_err;

    // stage 1: clock / baud
    logic          w_q_valid;
    logic [CW-1:0] w_q;
    logic [BW-1:0] w_q_baud;
    logic          w_q_zero;
    logic [CW:0]   w_sum16;
    logic [CW:0]   w_sum4;
    logic [CW-4:0] w_d16;
    logic [CW-2:0] w_d4;
    logic          r_s1_valid;
    logic          r_s1_zero;
    logic          r_s1_ok16;
    logic          r_s1_ok4;
    logic [DV-1:0] r_s1_d16;
    logic [DV-1:0] r_s1_d4;
    logic [BW-1:0] r_s1_baud;

    // stage 2: clock / divisor
    logic          w_a_valid;
    logic [CW-1:0] w_a16_q;
    logic [CW-1:0] w_a4_q;
    logic [DV-1:0] w_a16_d;
    logic [DV-1:0] w_a4_d;
    logic [BW+1:0] w_a16_side;
    logic          w_a4_side;
    logic [FW-1:0] w_act16;
    logic [FW-1:0] w_act4;
    logic [FW-1:0] w_baud_x;
    logic          r_s2_valid;
    logic          r_s2_zero;
    logic          r_s2_ok16;
    logic          r_s2_ok4;
    logic [DV-1:0] r_s2_d16;
    logic [DV-1:0] r_s2_d4;
    logic [BW-1:0] r_s2_baud;
    logic [FW-1:0] r_s2_diff16;
    logic [FW-1:0] r_s2_diff4;

    // stage 3: scale to ppm
    logic          r_s3_valid;
    logic          r_s3_zero;
    logic          r_s3_ok16;
    logic          r_s3_ok4;
    logic [DV-1:0] r_s3_d16;
    logic [DV-1:0] r_s3_d4;
    logic [BW-1:0] r_s3_baud;
    logic [PW-1:0] r_s3_n16;
    logic [PW-1:0] r_s3_n4;

    // stage 4: ppm error
    logic          w_e_valid;
    logic [PW-1:0] w_e16;
    logic [PW-1:0] w_e4;
    logic [DV+1:0] w_e16_side;
    logic [DV:0]   w_e4_side;

    logic          w_ok16;
    logic          w_ok4;
    logic          w_pick_hi;
    logic [PW-1:0] w_err;
    logic [DV-1:0] w_div;
    logic [DV-1:0] w_div_m1;
    ubds_pkg::t_status w_status;
    logic [15:0]   w_dm1_field;
    logic          w_hs_field;
    logic [EW-1:0] w_err_field;
    logic          r_out_valid;
    logic [39:0]   r_out_data;

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= CW'(16000000);
            r_max_err  <= EW'(50000);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ubds_pkg::CFG_CLOCK_HZ:  r_clock_hz <= i_cfg_data;
                ubds_pkg::CFG_MAX_ERROR: r_max_err  <= i_cfg_data[EW-1:0];
                default: ;
            endcase
        end
    end

    ubds_div_chain #(.DW(BW), .QW(CW), .SW(1)) u_div_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_num   (r_clock_hz),
        .i_den   (s_axis_tdata),
        .i_side  (s_axis_tdata == '0),
        .o_valid (w_q_valid),
        .o_quo   (w_q),
        .o_rem   (),
        .o_den   (w_q_baud),
        .o_side  (w_q_zero)
    );

    // round half up: floor((q + m/2) / m) with q = floor(clock / baud)
    always_comb begin
        w_sum16 = {1'b0, w_q} + (CW+1)'(8);
        w_sum4  = {1'b0, w_q} + (CW+1)'(2);
        w_d16   = w_sum16[CW:4];
        w_d4    = w_sum4[CW:2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= w_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_zero <= w_q_zero;
            r_s1_ok16 <= !w_q_zero && (w_d16 != '0) && (w_d16 <= (CW-3)'(DIVISOR_LIMIT));
            r_s1_ok4  <= !w_q_zero && (w_d4 != '0) && (w_d4 <= (CW-1)'(DIVISOR_LIMIT));
            r_s1_d16  <= w_d16[DV-1:0];
            r_s1_d4   <= w_d4[DV-1:0];
            r_s1_baud <= w_q_baud;
        end
    end

    ubds_div_chain #(.DW(DV), .QW(CW), .SW(BW+2)) u_div_act16 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s1_valid),
        .i_num   (r_clock_hz),
        .i_den   (r_s1_d16),
        .i_side  ({r_s1_zero, r_s1_ok16, r_s1_baud}),
        .o_valid (w_a_valid),
        .o_quo   (w_a16_q),
        .o_rem   (),
        .o_den   (w_a16_d),
        .o_side  (w_a16_side)
    );

    ubds_div_chain #(.DW(DV), .QW(CW), .SW(1)) u_div_act4 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s1_valid),
        .i_num   (r_clock_hz),
        .i_den   (r_s1_d4),
        .i_side  (r_s1_ok4),
        .o_valid (),
        .o_quo   (w_a4_q),
        .o_rem   (),
        .o_den   (w_a4_d),
        .o_side  (w_a4_side)
    );

    always_comb begin
        w_act16  = FW'(w_a16_q[CW-1:4]);
        w_act4   = w_a4_q[CW-1:2];
        w_baud_x = FW'(w_a16_side[BW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= w_a_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_zero   <= w_a16_side[BW+1];
            r_s2_ok16   <= w_a16_side[BW];
            r_s2_ok4    <= w_a4_side;
            r_s2_d16    <= w_a16_d;
            r_s2_d4     <= w_a4_d;
            r_s2_baud   <= w_a16_side[BW-1:0];
            r_s2_diff16 <= (w_act16 >= w_baud_x) ? w_act16 - w_baud_x : w_baud_x - w_act16;
            r_s2_diff4  <= (w_act4 >= w_baud_x) ? w_act4 - w_baud_x : w_baud_x - w_act4;
            r_s3_zero   <= r_s2_zero;
            r_s3_ok16   <= r_s2_ok16;
            r_s3_ok4    <= r_s2_ok4;
            r_s3_d16    <= r_s2_d16;
            r_s3_d4     <= r_s2_d4;
            r_s3_baud   <= r_s2_baud;
            r_s3_n16    <= PW'(r_s2_diff16) * PW'(ubds_pkg::PPM_SCALE);
            r_s3_n4     <= PW'(r_s2_diff4) * PW'(ubds_pkg::PPM_SCALE);
        end
    end

    ubds_div_chain #(.DW(BW), .QW(PW), .SW(DV+2)) u_div_err16 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s3_valid),
        .i_num   (r_s3_n16),
        .i_den   (r_s3_baud),
        .i_side  ({r_s3_zero, r_s3_ok16, r_s3_d16}),
        .o_valid (w_e_valid),
        .o_quo   (w_e16),
        .o_rem   (),
        .o_den   (),
        .o_side  (w_e16_side)
    );

    ubds_div_chain #(.DW(BW), .QW(PW), .SW(DV+1)) u_div_err4 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s3_valid),
        .i_num   (r_s3_n4),
        .i_den   (r_s3_baud),
        .i_side  ({r_s3_ok4, r_s3_d4}),
        .o_valid (),
        .o_quo   (w_e4),
        .o_rem   (),
        .o_den   (),
        .o_side  (w_e4_side)
    );

    always_comb begin
        w_ok16    = w_e16_side[DV] && !w_e16_side[DV+1];
        w_ok4     = w_e4_side[DV] && !w_e16_side[DV+1];
        // ties keep x16
        w_pick_hi = !w_ok16 || (w_ok4 && (w_e4 < w_e16));
        w_err     = w_pick_hi ? w_e4 : w_e16;
        w_div     = w_pick_hi ? w_e4_side[DV-1:0] : w_e16_side[DV-1:0];
        w_div_m1  = w_div - DV'(1);
        if (!w_ok16 && !w_ok4) begin
            w_status    = ubds_pkg::ST_NONE;
            w_dm1_field = '0;
            w_hs_field  = 1'b0;
            w_err_field = '0;
        end else begin
            w_status    = (w_err <= PW'(r_max_err)) ? ubds_pkg::ST_OK : ubds_pkg::ST_RANGE;
            w_dm1_field = w_div_m1[15:0];
            w_hs_field  = w_pick_hi;
            w_err_field = (w_err > PW'(ubds_pkg::ERR_MAX)) ? ubds_pkg::ERR_MAX
                                                           : w_err[EW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= {1'b0, w_err_field, w_hs_field, w_dm1_field, w_status};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

### hdl/ubds_div_cell.sv
// ---------------------------------------------------------------------------
// ubds_div_cell
// One restoring division step: shifts in a numerator bit, subtracts the
// divisor when it fits and hands the partial result to the next cell.
// ---------------------------------------------------------------------------
module ubds_div_cell #(
    parameter int unsigned DW = 24,
    parameter int unsigned QW = 28,
    parameter int unsigned SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_quo,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_rem,
    output logic [QW-1:0] o_quo,
    output logic [DW-1:0] o_den,
    output logic [SW-1:0] o_side
);

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_fit;
    logic [DW-1:0] n_rem;
    logic [QW-1:0] n_quo;
    logic          r_valid;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic [SW-1:0] r_side;

    always_comb begin
        w_trial = {i_rem, i_quo[QW-1]};
        w_diff  = w_trial - {1'b0, i_den};
        w_fit   = (w_trial >= {1'b0, i_den});
        n_rem   = w_fit ? w_diff[DW-1:0] : w_trial[DW-1:0];
        n_quo   = {i_quo[QW-2:0], w_fit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_den  <= i_den;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

### hdl/ubds_div_chain.sv
// ---------------------------------------------------------------------------
// ubds_div_chain
// Row of division cells, one quotient bit per cell, a new request each cycle while i_en is high.
// ---------------------------------------------------------------------------
module ubds_div_chain #(
    parameter int unsigned DW = 24,
    parameter int unsigned QW = 28,
    parameter int unsigned SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [QW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [DW-1:0] o_den,
    output logic [SW-1:0] o_side
);

    logic          w_valid [QW+1];
    logic [DW-1:0] w_rem   [QW+1];
    logic [QW-1:0] w_quo   [QW+1];
    logic [DW-1:0] w_den   [QW+1];
    logic [SW-1:0] w_side  [QW+1];

    assign w_valid[0] = i_valid;
    assign w_rem[0]   = '0;
    assign w_quo[0]   = i_num;
    assign w_den[0]   = i_den;
    assign w_side[0]  = i_side;

    for (genvar g = 0; g < QW; g++) begin : g_cell
        ubds_div_cell #(
            .DW (DW),
            .QW (QW),
            .SW (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_valid[g]),
            .i_rem   (w_rem[g]),
            .i_quo   (w_quo[g]),
            .i_den   (w_den[g]),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_quo   (w_quo[g+1]),
            .o_den   (w_den[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    assign o_valid = w_valid[QW];
    assign o_quo   = w_quo[QW];
    assign o_rem   = w_rem[QW];
    assign o_den   = w_den[QW];
    assign o_side  = w_side[QW];

endmodule

### hdl/ubds_checker.sv
// ---------------------------------------------------------------------------
// ubds_checker
// Port-level checks for uart_baud_divisor_select, bound to the top level.
// ---------------------------------------------------------------------------
module ubds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        o_cfg_ready
);

    // nothing comes out right after a reset cycle
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_status_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("bad status code");

    // rejected requests carry no divisor, mode or error
    a_reject_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == ubds_pkg::ST_NONE
            |-> m_axis_tdata[39:2] == '0)
        else $error("rejected result has nonzero fields");

    // backpressure is the only thing that holds off input requests
    a_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready && o_cfg_ready)
        else $error("input stalled with empty output");

endmodule

bind uart_baud_divisor_select ubds_checker u_ubds_checker (.*);
